### rtl/binary_grid_complement_match_defines.svh
// Assertion macros shared by the grid match RTL.
`ifndef BINARY_GRID_COMPLEMENT_MATCH_DEFINES_SVH
`define BINARY_GRID_COMPLEMENT_MATCH_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define BGCM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define BGCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bgcm_pkg.sv
// Package with codes, widths and interface types of the grid match block.
`timescale 1ns / 1ps
`default_nettype none
package bgcm_pkg;
  localparam int MAX_SIDE_DEF = 32;
  localparam int OP_W         = 2;
  localparam int IDX_W        = 5;
  localparam int SIZE_W       = 6;
  localparam int CFG_IDX_W    = 1;
  localparam int IN_DATA_W    = 16;
  localparam int OUT_DATA_W   = 8;

  localparam logic [OP_W-1:0] OP_KEY   = 2'd0;
  localparam logic [OP_W-1:0] OP_LOCK  = 2'd1;
  localparam logic [OP_W-1:0] OP_SOLVE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_SIZE = 1'd1;

  localparam logic [SIZE_W-1:0] SIZE_RST = 6'd3;

  typedef struct packed {
    logic wr_key;
    logic wr_lock;
    logic start;
    logic issue;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_row;
    logic found;
    logic busy;
  } dp_sts_t;
endpackage
`default_nettype wire

### rtl/bgcm_ram.sv
// Generic single-port-write RAM with bit write mask and registered read.
`timescale 1ns / 1ps
`default_nettype none
module bgcm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wmask,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      for (int b = 0; b < WIDTH; b++) begin
        if (wmask[b]) begin
          mem_r[waddr][b] <= wdata[b];
        end
      end
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

### rtl/bgcm_ctrl.sv
// Controller state machine of the grid match block.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_grid_complement_match_defines.svh"
module bgcm_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_fire,
  input  wire logic [bgcm_pkg::OP_W-1:0]  in_op,
  input  wire logic                       out_free,
  input  wire bgcm_pkg::dp_sts_t          sts,
  output bgcm_pkg::ctrl_cmd_t             cmd,
  output logic                            in_tready
);
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    in_tready   = (state_r == S_IDLE);
    cmd.wr_key  = in_fire && (in_op == bgcm_pkg::OP_KEY);
    cmd.wr_lock = in_fire && (in_op == bgcm_pkg::OP_LOCK);
    cmd.start   = in_fire && (in_op == bgcm_pkg::OP_SOLVE);
    cmd.issue   = (state_r == S_RUN) && !sts.found;
    cmd.emit    = (state_r == S_DONE) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.start) state_nxt = S_RUN;
      end
      S_RUN: begin
        if (sts.found || sts.last_row) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.busy) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `BGCM_ASSERT_NEXT(a_start_issues, clk, rst_n, cmd.start, cmd.issue, "solve did not start issuing rows")
  `BGCM_ASSERT_NOW(a_wr_idle_pipe, clk, rst_n, cmd.wr_key || cmd.wr_lock, !sts.busy, "cell write during a search")
  `BGCM_ASSERT_NOW(a_emit_drained, clk, rst_n, cmd.emit, !sts.busy, "result emitted before the pipeline drained")
endmodule
`default_nettype wire

### rtl/bgcm_dp.sv
// Datapath of the grid match block: grid stores, placement counters, row check.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_grid_complement_match_defines.svh"
module bgcm_dp #(
  parameter int MAX_SIDE = bgcm_pkg::MAX_SIDE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire bgcm_pkg::ctrl_cmd_t           cmd,
  input  wire logic [bgcm_pkg::SIZE_W-1:0]   key_size,
  input  wire logic [bgcm_pkg::SIZE_W-1:0]   lock_size,
  input  wire logic [bgcm_pkg::IDX_W-1:0]    row,
  input  wire logic [bgcm_pkg::IDX_W-1:0]    col,
  input  wire logic                          cell_bit,
  output bgcm_pkg::dp_sts_t                  sts
);
  localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int CW = SW + 2;
  localparam int EW = bgcm_pkg::IDX_W + 2;
  localparam logic [EW-1:0] SIDE_EXT = EW'(MAX_SIDE);
  localparam logic [bgcm_pkg::SIZE_W:0] SIZE_MAX_EXT = (bgcm_pkg::SIZE_W + 1)'(MAX_SIDE);

  function automatic logic [SW-1:0] eff_size(input logic [bgcm_pkg::SIZE_W-1:0] v);
    logic [SW-1:0] r;
    if (v == '0) r = SW'(1);
    else if ({1'b0, v} > SIZE_MAX_EXT) r = SW'(MAX_SIDE);
    else r = SW'({1'b0, v});
    return r;
  endfunction

  logic [SW-1:0]        kn;
  logic [SW-1:0]        ln;
  logic signed [CW-1:0] kn_s;
  logic signed [CW-1:0] ln_s;

  assign kn   = eff_size(key_size);
  assign ln   = eff_size(lock_size);
  assign kn_s = signed'(CW'(kn));
  assign ln_s = signed'(CW'(ln));

  // Cell writes: one bit of one row, and the transposed copy for the key.
  logic                cell_ok;
  logic [MAX_SIDE-1:0] col_mask;
  logic [MAX_SIDE-1:0] row_mask;
  logic [MAX_SIDE-1:0] cell_data;

  assign cell_ok   = (EW'(row) < SIDE_EXT) && (EW'(col) < SIDE_EXT);
  assign col_mask  = MAX_SIDE'(1) << col;
  assign row_mask  = MAX_SIDE'(1) << row;
  assign cell_data = {MAX_SIDE{cell_bit}};

  // Placement counters, the lock row counter innermost.
  logic [1:0]           rot_r;
  logic signed [CW-1:0] oi_r;
  logic signed [CW-1:0] oj_r;
  logic [SW-1:0]        ri_r;
  logic signed [CW-1:0] off_min;
  logic                 ri_last;
  logic                 oj_last;
  logic                 oi_last;

  assign off_min = signed'(CW'(1)) - ln_s;
  assign ri_last = (ri_r == SW'(ln - SW'(1)));
  assign oj_last = (oj_r == kn_s - signed'(CW'(1)));
  assign oi_last = (oi_r == kn_s - signed'(CW'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r <= '0;
      oi_r  <= '0;
      oj_r  <= '0;
      ri_r  <= '0;
    end else if (cmd.start) begin
      rot_r <= '0;
      oi_r  <= off_min;
      oj_r  <= off_min;
      ri_r  <= '0;
    end else if (cmd.issue) begin
      if (!ri_last) begin
        ri_r <= ri_r + SW'(1);
      end else begin
        ri_r <= '0;
        if (!oj_last) begin
          oj_r <= oj_r + signed'(CW'(1));
        end else begin
          oj_r <= off_min;
          if (!oi_last) begin
            oi_r <= oi_r + signed'(CW'(1));
          end else begin
            oi_r  <= off_min;
            rot_r <= rot_r + 2'd1;
          end
        end
      end
    end
  end

  // Issue stage: key row of the rotated grid and its read address.
  logic signed [CW-1:0] ki;
  logic signed [CW-1:0] ki_rev;
  logic [CW-1:0]        key_idx;
  logic                 ki_in;
  logic                 rev;
  logic signed [CW-1:0] base;
  logic [AW-1:0]        key_addr;
  logic [AW-1:0]        lock_addr;

  always_comb begin
    ki        = oi_r + signed'(CW'(ri_r));
    ki_rev    = kn_s - signed'(CW'(1)) - ki;
    ki_in     = (ki >= 0) && (ki < kn_s);
    key_idx   = rot_r[1] ? unsigned'(ki_rev) : unsigned'(ki);
    key_addr  = key_idx[AW-1:0];
    lock_addr = AW'(ri_r);
    rev       = rot_r[0] ^ rot_r[1];
    base      = rev ? (kn_s - signed'(CW'(1)) - oj_r) : oj_r;
  end

  logic [MAX_SIDE-1:0] krow_rd;
  logic [MAX_SIDE-1:0] kcol_rd;
  logic [MAX_SIDE-1:0] lock_rd;

  bgcm_ram #(.WIDTH(MAX_SIDE), .DEPTH(MAX_SIDE)) u_key_rows (
    .clk   (clk),
    .we    (cmd.wr_key && cell_ok),
    .waddr (AW'(row)),
    .wmask (col_mask),
    .wdata (cell_data),
    .raddr (key_addr),
    .rdata (krow_rd)
  );

  bgcm_ram #(.WIDTH(MAX_SIDE), .DEPTH(MAX_SIDE)) u_key_cols (
    .clk   (clk),
    .we    (cmd.wr_key && cell_ok),
    .waddr (AW'(col)),
    .wmask (row_mask),
    .wdata (cell_data),
    .raddr (key_addr),
    .rdata (kcol_rd)
  );

  bgcm_ram #(.WIDTH(MAX_SIDE), .DEPTH(MAX_SIDE)) u_lock_rows (
    .clk   (clk),
    .we    (cmd.wr_lock && cell_ok),
    .waddr (AW'(row)),
    .wmask (col_mask),
    .wdata (cell_data),
    .raddr (lock_addr),
    .rdata (lock_rd)
  );

  // Tag that travels beside the memory read.
  logic                 p1_valid_r;
  logic                 p1_in_r;
  logic                 p1_colsel_r;
  logic                 p1_rev_r;
  logic signed [CW-1:0] p1_base_r;
  logic                 p1_first_r;
  logic                 p1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      p1_in_r     <= ki_in;
      p1_colsel_r <= rot_r[0];
      p1_rev_r    <= rev;
      p1_base_r   <= base;
      p1_first_r  <= (ri_r == '0);
      p1_last_r   <= ri_last;
    end
  end

  // Row check: each lane compares one lock cell with the key cell above it.
  logic [MAX_SIDE-1:0]  key_vec;
  logic signed [CW-1:0] raw [MAX_SIDE];
  logic [MAX_SIDE-1:0]  cov;
  logic [MAX_SIDE-1:0]  mism;
  logic                 row_fail;
  logic                 fail_now;

  always_comb begin
    key_vec = p1_colsel_r ? kcol_rd : krow_rd;
    for (int j = 0; j < MAX_SIDE; j++) begin
      raw[j]  = p1_rev_r ? (p1_base_r - signed'(CW'(j))) : (p1_base_r + signed'(CW'(j)));
      cov[j]  = p1_in_r && (raw[j] >= 0) && (raw[j] < kn_s);
      mism[j] = (SW'(j) < ln) &&
                (cov[j] ? (key_vec[raw[j][AW-1:0]] == lock_rd[j]) : !lock_rd[j]);
    end
    row_fail = |mism;
  end

  logic acc_fail_r;
  logic found_r;

  assign fail_now = (p1_first_r ? 1'b0 : acc_fail_r) | row_fail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_fail_r <= 1'b0;
      found_r    <= 1'b0;
    end else if (cmd.start) begin
      acc_fail_r <= 1'b0;
      found_r    <= 1'b0;
    end else if (p1_valid_r) begin
      acc_fail_r <= fail_now;
      if (p1_last_r && !fail_now) found_r <= 1'b1;
    end
  end

  always_comb begin
    sts.last_row = cmd.issue && (rot_r == 2'd3) && oi_last && oj_last && ri_last;
    sts.found    = found_r;
    sts.busy     = p1_valid_r;
  end

  `BGCM_ASSERT_NEXT(a_found_holds, clk, rst_n, found_r && !cmd.start, found_r, "fit flag dropped during a solve")
  `BGCM_ASSERT_NOW(a_tag_from_issue, clk, rst_n, p1_valid_r, $past(cmd.issue), "row check without a row issued")
endmodule
`default_nettype wire

### rtl/binary_grid_complement_match.sv
// Top level of the binary grid complement match block.
// The input stream carries one beat per item: a key cell write, a lock cell
// write or a solve request. Cell writes are taken one per cycle while the
// block is idle and give no result. A solve tries the four quarter turns of
// the key at every offset where it overlaps the lock and returns one beat
// whose bit says whether some placement fills the lock.
// A solve checks one lock row per cycle, all columns of that row at once, and
// stops early at the first placement that fits. It loops over the lock rows
// because each grid store has a single read port.
// No input beat is taken while a solve runs.
// The result waits in an output register; a new cell write is taken while the
// receiver stalls, but a finished solve holds until that register is free.
// Reset sets both sizes to three and empties the pipeline; the grid stores
// are not cleared and must be written before they are searched.
// Configuration writes through cfg_we, cfg_idx and cfg_wdata take effect at
// once and must only be made while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module binary_grid_complement_match #(
  parameter int MAX_SIDE = bgcm_pkg::MAX_SIDE_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // op [1:0], row [6:2], col [11:7], cell_bit [12], zeros above
  input  wire logic [bgcm_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // fits [0], zeros above
  output logic      [bgcm_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  wire logic                                cfg_we,
  input  wire logic [bgcm_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [bgcm_pkg::SIZE_W-1:0]         cfg_wdata
);
  logic [bgcm_pkg::OP_W-1:0]   in_op;
  logic [bgcm_pkg::IDX_W-1:0]  in_row;
  logic [bgcm_pkg::IDX_W-1:0]  in_col;
  logic                        in_cell_bit;
  logic                        in_fire;
  logic                        out_free;

  bgcm_pkg::ctrl_cmd_t cmd;
  bgcm_pkg::dp_sts_t   sts;

  logic [bgcm_pkg::SIZE_W-1:0] key_size_r;
  logic [bgcm_pkg::SIZE_W-1:0] lock_size_r;
  logic                        out_tvalid_r;
  logic                        out_fits_r;

  assign in_op       = in_tdata[1:0];
  assign in_row      = in_tdata[6:2];
  assign in_col      = in_tdata[11:7];
  assign in_cell_bit = in_tdata[12];
  assign in_fire     = in_tvalid && in_tready;
  assign out_free    = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_size_r  <= bgcm_pkg::SIZE_RST;
      lock_size_r <= bgcm_pkg::SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bgcm_pkg::CFG_KEY_SIZE:  key_size_r  <= cfg_wdata;
        bgcm_pkg::CFG_LOCK_SIZE: lock_size_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bgcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_op     (in_op),
    .out_free  (out_free),
    .sts       (sts),
    .cmd       (cmd),
    .in_tready (in_tready)
  );

  bgcm_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .key_size  (key_size_r),
    .lock_size (lock_size_r),
    .row       (in_row),
    .col       (in_col),
    .cell_bit  (in_cell_bit),
    .sts       (sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_fits_r <= sts.found;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(bgcm_pkg::OUT_DATA_W - 1)'(0), out_fits_r};
endmodule
`default_nettype wire
